/* sv/m4vt_pkg.sv */
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared constants, operation codes and the token struct for the 4x4
// matrix by 4-vector transform engine.
// ----------------------------------------------------------------------------
package m4vt_pkg;

    // Default number format: signed Q16.16 in 32-bit words
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    // Matrix geometry
    localparam int NUM_LANES = 4;
    localparam int COL_BITS  = 2;

    // Operation codes
    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_TRANSFORM = 1'b1;

    // Control part of a word travelling down the chain
    typedef struct packed {
        logic                valid;
        logic                op;
        logic [COL_BITS-1:0] col;
    } tok_t;

endpackage

/* sv/m4vt_cmd_if.sv */
// ----------------------------------------------------------------------------
// m4vt_cmd_if
// Input channel: load-column or transform words with valid/ready.
// ----------------------------------------------------------------------------
interface m4vt_cmd_if #(
    parameter int WORD_BITS = m4vt_pkg::WORD_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [m4vt_pkg::COL_BITS-1:0]       column_index;
    logic signed [WORD_BITS-1:0]         comp_0;
    logic signed [WORD_BITS-1:0]         comp_1;
    logic signed [WORD_BITS-1:0]         comp_2;
    logic signed [WORD_BITS-1:0]         comp_3;

    modport source (
        output valid, operation, column_index, comp_0, comp_1, comp_2, comp_3,
        input  ready
    );

    modport sink (
        input  valid, operation, column_index, comp_0, comp_1, comp_2, comp_3,
        output ready
    );
endinterface

/* sv/m4vt_res_if.sv */
// ----------------------------------------------------------------------------
// m4vt_res_if
// Output channel: one transformed vector per word with valid/ready.
// ----------------------------------------------------------------------------
interface m4vt_res_if #(
    parameter int WORD_BITS = m4vt_pkg::WORD_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] out_0;
    logic signed [WORD_BITS-1:0] out_1;
    logic signed [WORD_BITS-1:0] out_2;
    logic signed [WORD_BITS-1:0] out_3;

    modport source (
        output valid, out_0, out_1, out_2, out_3,
        input  ready
    );

    modport sink (
        input  valid, out_0, out_1, out_2, out_3,
        output ready
    );
endinterface

/* sv/m4vt_cell.sv */
// ----------------------------------------------------------------------------
// m4vt_cell
// One column cell of the chain: holds one matrix column, multiplies it by
// its vector element and adds the products onto the partial row sums.
// ----------------------------------------------------------------------------
module m4vt_cell #(
    parameter int                            WORD_BITS = m4vt_pkg::WORD_BITS_DEF,
    parameter int                            ACC_BITS  = 2 * WORD_BITS + 2,
    parameter logic [m4vt_pkg::COL_BITS-1:0] COL       = '0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  m4vt_pkg::tok_t             tok_in,
    input  logic signed [WORD_BITS-1:0] vec_in  [m4vt_pkg::NUM_LANES],
    input  logic signed [ACC_BITS-1:0]  acc_in  [m4vt_pkg::NUM_LANES],
    output m4vt_pkg::tok_t             tok_out,
    output logic signed [WORD_BITS-1:0] vec_out [m4vt_pkg::NUM_LANES],
    output logic signed [ACC_BITS-1:0]  acc_out [m4vt_pkg::NUM_LANES]
);

    localparam int PROD_BITS = 2 * WORD_BITS;

    logic signed [WORD_BITS-1:0] col_reg     [m4vt_pkg::NUM_LANES];
    logic signed [PROD_BITS-1:0] prod_next   [m4vt_pkg::NUM_LANES];
    logic signed [PROD_BITS-1:0] prod_reg    [m4vt_pkg::NUM_LANES];
    logic signed [WORD_BITS-1:0] vec_a_reg   [m4vt_pkg::NUM_LANES];
    logic signed [ACC_BITS-1:0]  acc_a_reg   [m4vt_pkg::NUM_LANES];
    logic signed [WORD_BITS-1:0] vec_out_reg [m4vt_pkg::NUM_LANES];
    logic signed [ACC_BITS-1:0]  acc_out_reg [m4vt_pkg::NUM_LANES];
    m4vt_pkg::tok_t              tok_a_reg;
    m4vt_pkg::tok_t              tok_out_reg;
    logic                        col_wr;

    // Write this column when a load word for it enters the cell
    assign col_wr = advance && tok_in.valid && (tok_in.op == m4vt_pkg::OP_LOAD)
                    && (tok_in.col == COL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < m4vt_pkg::NUM_LANES; r++)
            begin
                col_reg[r] <= '0;
            end
        end
        else if (col_wr)
        begin
            for (int r = 0; r < m4vt_pkg::NUM_LANES; r++)
            begin
                col_reg[r] <= vec_in[r];
            end
        end
    end

    // Full-width products of the stored column with this cell's element
    always_comb
    begin
        for (int r = 0; r < m4vt_pkg::NUM_LANES; r++)
        begin
            prod_next[r] = col_reg[r] * vec_in[COL];
        end
    end

    // Advance control through both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg   <= '0;
            tok_out_reg <= '0;
        end
        else if (advance)
        begin
            tok_a_reg   <= tok_in;
            tok_out_reg <= tok_a_reg;
        end
    end

    // Stage A: register products; stage B: accumulate
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int r = 0; r < m4vt_pkg::NUM_LANES; r++)
            begin
                prod_reg[r]    <= prod_next[r];
                vec_a_reg[r]   <= vec_in[r];
                acc_a_reg[r]   <= acc_in[r];
                vec_out_reg[r] <= vec_a_reg[r];
                acc_out_reg[r] <= acc_a_reg[r] + ACC_BITS'(prod_reg[r]);
            end
        end
    end

    assign tok_out = tok_out_reg;
    assign vec_out = vec_out_reg;
    assign acc_out = acc_out_reg;

endmodule

/* sv/m4vt_sat.sv */
// ----------------------------------------------------------------------------
// m4vt_sat
// Output stage: drops the fraction bits of each row sum, saturates to the
// word range and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module m4vt_sat #(
    parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = m4vt_pkg::WORD_BITS_DEF,
    parameter int ACC_BITS  = 2 * WORD_BITS + 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  m4vt_pkg::tok_t              tok_in,
    input  logic signed [ACC_BITS-1:0]  acc_in   [m4vt_pkg::NUM_LANES],
    output logic                        out_valid,
    output logic signed [WORD_BITS-1:0] out_data [m4vt_pkg::NUM_LANES]
);

    localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam int UPPER_BITS = ACC_BITS - WORD_BITS + 1;

    logic signed [ACC_BITS-1:0]  shifted  [m4vt_pkg::NUM_LANES];
    logic [UPPER_BITS-1:0]       upper    [m4vt_pkg::NUM_LANES];
    logic signed [WORD_BITS-1:0] sat_next [m4vt_pkg::NUM_LANES];
    logic signed [WORD_BITS-1:0] data_reg [m4vt_pkg::NUM_LANES];
    logic                        valid_reg;

    // Shift toward minus infinity, then clamp when the top bits disagree
    always_comb
    begin
        for (int r = 0; r < m4vt_pkg::NUM_LANES; r++)
        begin
            shifted[r] = acc_in[r] >>> FRAC_BITS;
            upper[r]   = shifted[r][ACC_BITS-1:WORD_BITS-1];
            if ((&upper[r]) || !(|upper[r]))
            begin
                sat_next[r] = shifted[r][WORD_BITS-1:0];
            end
            else if (shifted[r][ACC_BITS-1])
            begin
                sat_next[r] = W_MIN;
            end
            else
            begin
                sat_next[r] = W_MAX;
            end
        end
    end

    // Only transform words yield a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= tok_in.valid && (tok_in.op == m4vt_pkg::OP_TRANSFORM);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int r = 0; r < m4vt_pkg::NUM_LANES; r++)
            begin
                data_reg[r] <= sat_next[r];
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* sv/mat4_vec4_transform.sv */
// ----------------------------------------------------------------------------
// mat4_vec4_transform
// 4x4 signed fixed-point matrix by 4-vector transform, built as a chain of
// four column cells followed by a shift-and-saturate output register.
// ----------------------------------------------------------------------------
// Transform words run through the four column cells, then the output register.
// Throughput: one word (load or transform) per cycle unless a result word
// stalls the chain; each column cell has a multiply and an accumulate stage.
// A result word not taken stalls the whole chain and holds cmd.ready low.
// Reset clears the stored matrix to zero and empties the chain.
// ----------------------------------------------------------------------------
module mat4_vec4_transform #(
    parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = m4vt_pkg::WORD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    m4vt_cmd_if.sink    cmd,
    m4vt_res_if.source  res
);

    localparam int NL       = m4vt_pkg::NUM_LANES;
    localparam int ACC_BITS = 2 * WORD_BITS + 2;

    m4vt_pkg::tok_t              tok_c [NL+1];
    logic signed [WORD_BITS-1:0] vec_c [NL+1][NL];
    logic signed [ACC_BITS-1:0]  acc_c [NL+1][NL];
    logic signed [WORD_BITS-1:0] out_data [NL];
    logic                        out_valid;
    logic                        advance;

    // Move the whole chain unless a result word is waiting
    assign advance   = !out_valid || res.ready;
    assign cmd.ready = advance;

    // Head of the chain
    assign tok_c[0].valid = cmd.valid;
    assign tok_c[0].op    = cmd.operation;
    assign tok_c[0].col   = cmd.column_index;
    assign vec_c[0][0]    = cmd.comp_0;
    assign vec_c[0][1]    = cmd.comp_1;
    assign vec_c[0][2]    = cmd.comp_2;
    assign vec_c[0][3]    = cmd.comp_3;

    for (genvar r = 0; r < NL; r++)
    begin : g_acc_zero
        assign acc_c[0][r] = '0;
    end

    // Column cells
    for (genvar i = 0; i < NL; i++)
    begin : g_cell
        m4vt_cell #(
            .WORD_BITS (WORD_BITS),
            .ACC_BITS  (ACC_BITS),
            .COL       (m4vt_pkg::COL_BITS'(i))
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (tok_c[i]),
            .vec_in  (vec_c[i]),
            .acc_in  (acc_c[i]),
            .tok_out (tok_c[i+1]),
            .vec_out (vec_c[i+1]),
            .acc_out (acc_c[i+1])
        );
    end

    // Shift, saturate and hold the result
    m4vt_sat #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS),
        .ACC_BITS  (ACC_BITS)
    ) u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .tok_in    (tok_c[NL]),
        .acc_in    (acc_c[NL]),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign res.valid = out_valid;
    assign res.out_0 = out_data[0];
    assign res.out_1 = out_data[1];
    assign res.out_2 = out_data[2];
    assign res.out_3 = out_data[3];

endmodule

/* sv/m4vt_check.sv */
// ----------------------------------------------------------------------------
// m4vt_check
// Port-level checks for the transform engine, bound to the top level.
// ----------------------------------------------------------------------------
module m4vt_check #(
    parameter int WORD_BITS = m4vt_pkg::WORD_BITS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        cmd_ready,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic signed [WORD_BITS-1:0] res_out_0,
    input logic signed [WORD_BITS-1:0] res_out_3
);

    // A waiting result word stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word withdrawn while stalled");

    // A waiting result word keeps its value
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_out_0) && $stable(res_out_3))
        else $error("result word changed while stalled");

    // Input is refused exactly when a result word is held back
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready == (!res_valid || res_ready))
        else $error("input ready does not follow output stall");

    // Nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !res_valid)
        else $error("result word right after reset");

endmodule

bind mat4_vec4_transform m4vt_check #(
    .WORD_BITS (WORD_BITS)
) u_m4vt_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_out_0 (res.out_0),
    .res_out_3 (res.out_3)
);
